### rtl/ubxfr_pkg.sv
// Shared types, constants and register indexes of the UBX frame receiver.
package ubxfr_pkg;

   // Field widths.
   localparam int ByteW    = 8;
   localparam int LenW     = 16;
   localparam int CsrIdxW  = 2;
   localparam int CsrDataW = 16;

   // Configuration register indexes.
   localparam logic [CsrIdxW-1:0] CSR_SYNC_FIRST  = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_SYNC_SECOND = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_MAX_LENGTH  = 2'd2;

   // Configuration reset values.
   localparam logic [ByteW-1:0] SYNC_FIRST_RESET  = 8'hB5;
   localparam logic [ByteW-1:0] SYNC_SECOND_RESET = 8'h62;
   localparam logic [LenW-1:0]  MAX_LENGTH_RESET  = 16'd512;

   // Receiver phase.
   typedef enum logic [3:0] {
      PH_HUNT1   = 4'd0,
      PH_HUNT2   = 4'd1,
      PH_CLASS   = 4'd2,
      PH_ID      = 4'd3,
      PH_LEN1    = 4'd4,
      PH_LEN2    = 4'd5,
      PH_PAYLOAD = 4'd6,
      PH_CK1     = 4'd7,
      PH_CK2     = 4'd8
   } phase_type;

   // Frame end status codes.
   typedef enum logic [1:0] {
      ST_NONE  = 2'd0,
      ST_GOOD  = 2'd1,
      ST_BADCK = 2'd2,
      ST_LONG  = 2'd3
   } status_type;

   // Configuration register set.
   typedef struct packed {
      logic [ByteW-1:0] sync_first;
      logic [ByteW-1:0] sync_second;
      logic [LenW-1:0]  max_length;
   } cfg_type;

   // One result word.
   typedef struct packed {
      logic [ByteW-1:0] payload_byte;
      logic             payload_valid;
      logic [LenW-1:0]  payload_offset;
      status_type       frame_status;
      logic [ByteW-1:0] msg_class;
      logic [ByteW-1:0] msg_id;
      logic [LenW-1:0]  payload_length;
   } rsp_word_type;

endpackage

### rtl/ubxfr_req_if.sv
// Input channel carrying one received serial byte per word.
interface ubxfr_req_if;
   logic                      valid;
   logic                      ready;
   logic [ubxfr_pkg::ByteW-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

### rtl/ubxfr_rsp_if.sv
// Result channel carrying one parsed result per input byte.
interface ubxfr_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [ubxfr_pkg::ByteW-1:0] payload_byte;
   logic                        payload_valid;
   logic [ubxfr_pkg::LenW-1:0]  payload_offset;
   logic [1:0]                  frame_status;
   logic [ubxfr_pkg::ByteW-1:0] msg_class;
   logic [ubxfr_pkg::ByteW-1:0] msg_id;
   logic [ubxfr_pkg::LenW-1:0]  payload_length;

   modport source (
      output valid, output payload_byte, output payload_valid, output payload_offset,
      output frame_status, output msg_class, output msg_id, output payload_length,
      input ready
   );
   modport sink (
      input valid, input payload_byte, input payload_valid, input payload_offset,
      input frame_status, input msg_class, input msg_id, input payload_length,
      output ready
   );
endinterface

### rtl/ubxfr_csr.sv
// Configuration registers: sync bytes and maximum payload length.
module ubxfr_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [ubxfr_pkg::CsrIdxW-1:0]      csr_index,
   input  logic [ubxfr_pkg::CsrDataW-1:0]     csr_wdata,
   output ubxfr_pkg::cfg_type                 cfg
);

   ubxfr_pkg::cfg_type cfg_ff;
   ubxfr_pkg::cfg_type cfg_in;

   // Decode the write; an index beyond the list changes nothing.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            ubxfr_pkg::CSR_SYNC_FIRST: begin
               cfg_in.sync_first = csr_wdata[ubxfr_pkg::ByteW-1:0];
            end
            ubxfr_pkg::CSR_SYNC_SECOND: begin
               cfg_in.sync_second = csr_wdata[ubxfr_pkg::ByteW-1:0];
            end
            ubxfr_pkg::CSR_MAX_LENGTH: begin
               cfg_in.max_length = csr_wdata[ubxfr_pkg::LenW-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_first  <= ubxfr_pkg::SYNC_FIRST_RESET;
         cfg_ff.sync_second <= ubxfr_pkg::SYNC_SECOND_RESET;
         cfg_ff.max_length  <= ubxfr_pkg::MAX_LENGTH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/ubxfr_parser.sv
// Frame state machine with running Fletcher sums; yields one result per byte.
module ubxfr_parser (
   input  logic                           clock,
   input  logic                           reset,
   input  ubxfr_pkg::cfg_type             cfg,
   input  logic                           step,
   input  logic [ubxfr_pkg::ByteW-1:0]    rx_byte,
   output ubxfr_pkg::rsp_word_type        result
);

   ubxfr_pkg::phase_type              phase_ff, phase_in;
   logic [ubxfr_pkg::ByteW-1:0]       class_ff, class_in;
   logic [ubxfr_pkg::ByteW-1:0]       id_ff, id_in;
   logic [ubxfr_pkg::LenW-1:0]        length_ff, length_in;
   logic [ubxfr_pkg::LenW-1:0]        count_ff, count_in;
   logic [ubxfr_pkg::ByteW-1:0]       sum_a_ff, sum_a_in;
   logic [ubxfr_pkg::ByteW-1:0]       sum_b_ff, sum_b_in;

   logic [ubxfr_pkg::ByteW-1:0]       acc_a;
   logic [ubxfr_pkg::ByteW-1:0]       acc_b;
   logic [ubxfr_pkg::LenW-1:0]        length_full;
   logic [ubxfr_pkg::LenW-1:0]        count_inc;

   // Fletcher update, full length and next payload count; all wrap at their width.
   assign acc_a       = sum_a_ff + rx_byte;
   assign acc_b       = sum_b_ff + acc_a;
   assign length_full = {rx_byte, length_ff[ubxfr_pkg::ByteW-1:0]};
   assign count_inc   = count_ff + 16'd1;

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         ubxfr_pkg::PH_HUNT1: begin
            phase_in = (rx_byte == cfg.sync_first) ? ubxfr_pkg::PH_HUNT2
                                                   : ubxfr_pkg::PH_HUNT1;
         end
         ubxfr_pkg::PH_HUNT2: begin
            phase_in = (rx_byte == cfg.sync_second) ? ubxfr_pkg::PH_CLASS
                                                    : ubxfr_pkg::PH_HUNT1;
         end
         ubxfr_pkg::PH_CLASS: begin
            phase_in = ubxfr_pkg::PH_ID;
         end
         ubxfr_pkg::PH_ID: begin
            phase_in = ubxfr_pkg::PH_LEN1;
         end
         ubxfr_pkg::PH_LEN1: begin
            phase_in = ubxfr_pkg::PH_LEN2;
         end
         ubxfr_pkg::PH_LEN2: begin
            if (length_full > cfg.max_length) begin
               phase_in = ubxfr_pkg::PH_HUNT1;
            end else if (length_full == '0) begin
               phase_in = ubxfr_pkg::PH_CK1;
            end else begin
               phase_in = ubxfr_pkg::PH_PAYLOAD;
            end
         end
         ubxfr_pkg::PH_PAYLOAD: begin
            if (count_inc >= length_ff) begin
               phase_in = ubxfr_pkg::PH_CK1;
            end
         end
         ubxfr_pkg::PH_CK1: begin
            phase_in = (rx_byte == sum_a_ff) ? ubxfr_pkg::PH_CK2 : ubxfr_pkg::PH_HUNT1;
         end
         ubxfr_pkg::PH_CK2: begin
            phase_in = ubxfr_pkg::PH_HUNT1;
         end
         default: begin
            phase_in = ubxfr_pkg::PH_HUNT1;
         end
      endcase
   end

   // Frame fields, sums and the result word.
   always_comb begin
      class_in = class_ff;
      id_in    = id_ff;
      length_in = length_ff;
      count_in = count_ff;
      sum_a_in = sum_a_ff;
      sum_b_in = sum_b_ff;
      result   = '0;
      result.frame_status = ubxfr_pkg::ST_NONE;
      unique case (phase_ff)
         ubxfr_pkg::PH_HUNT1: begin
            // A first sync byte opens a fresh frame.
            if (rx_byte == cfg.sync_first) begin
               class_in  = '0;
               id_in     = '0;
               length_in = '0;
               count_in  = '0;
               sum_a_in  = '0;
               sum_b_in  = '0;
            end
         end
         ubxfr_pkg::PH_HUNT2: begin
            result.frame_status = ubxfr_pkg::ST_NONE;
         end
         ubxfr_pkg::PH_CLASS: begin
            class_in = rx_byte;
            sum_a_in = acc_a;
            sum_b_in = acc_b;
         end
         ubxfr_pkg::PH_ID: begin
            id_in    = rx_byte;
            sum_a_in = acc_a;
            sum_b_in = acc_b;
         end
         ubxfr_pkg::PH_LEN1: begin
            length_in = {{(ubxfr_pkg::LenW-ubxfr_pkg::ByteW){1'b0}}, rx_byte};
            sum_a_in  = acc_a;
            sum_b_in  = acc_b;
         end
         ubxfr_pkg::PH_LEN2: begin
            length_in = length_full;
            sum_a_in  = acc_a;
            sum_b_in  = acc_b;
            if (length_full > cfg.max_length) begin
               result.frame_status = ubxfr_pkg::ST_LONG;
            end
         end
         ubxfr_pkg::PH_PAYLOAD: begin
            result.payload_byte   = rx_byte;
            result.payload_valid  = 1'b1;
            result.payload_offset = count_ff;
            sum_a_in = acc_a;
            sum_b_in = acc_b;
            count_in = count_inc;
         end
         ubxfr_pkg::PH_CK1: begin
            if (rx_byte != sum_a_ff) begin
               result.frame_status = ubxfr_pkg::ST_BADCK;
            end
         end
         ubxfr_pkg::PH_CK2: begin
            result.frame_status = (rx_byte == sum_b_ff) ? ubxfr_pkg::ST_GOOD
                                                        : ubxfr_pkg::ST_BADCK;
         end
         default: begin
            if (rx_byte == cfg.sync_first) begin
               class_in  = '0;
               id_in     = '0;
               length_in = '0;
               count_in  = '0;
               sum_a_in  = '0;
               sum_b_in  = '0;
            end
         end
      endcase
      result.msg_class      = class_in;
      result.msg_id         = id_in;
      result.payload_length = length_in;
   end

   // State registers advance once per processed byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= ubxfr_pkg::PH_HUNT1;
         class_ff  <= '0;
         id_ff     <= '0;
         length_ff <= '0;
         count_ff  <= '0;
         sum_a_ff  <= '0;
         sum_b_ff  <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         class_ff  <= class_in;
         id_ff     <= id_in;
         length_ff <= length_in;
         count_ff  <= count_in;
         sum_a_ff  <= sum_a_in;
         sum_b_ff  <= sum_b_in;
      end
   end

endmodule

### rtl/ubx_frame_receiver_unit.sv
// Top level of the UBX frame receiver: input register, parser and result register.
//
// Usage:
//   The req channel takes one received serial byte per word. The rsp channel
//   returns exactly one result word per byte: the payload byte with its offset
//   when the byte belongs to the payload, the frame end status on the last
//   checksum byte (or the first one if wrong, or the second length byte of an
//   over-long frame), and the class, id and declared length of the current frame.
//   The csr port writes sync_first (index 0), sync_second (index 1) and
//   max_length (index 2); the user must write it only while idle (not enforced).
// Pipeline:
//   An accepted byte sits in the input register, then its result in the result
//   register that drives rsp. One byte is taken every cycle while rsp is not
//   held; the byte register feeds the parser and the result register in one pass.
// Reset:
//   Synchronous, active high. Both registers empty, the parser hunts for the
//   first sync byte and the configuration returns to 0xB5, 0x62 and 512.
// Stalls:
//   While rsp is held, the result register keeps its word, the parser holds
//   its state, and req can still take one more byte into the input register.
module ubx_frame_receiver_unit (
   input  logic                             clock,
   input  logic                             reset,
   ubxfr_req_if.sink                        req,
   ubxfr_rsp_if.source                      rsp,
   input  logic                             csr_we,
   input  logic [ubxfr_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [ubxfr_pkg::CsrDataW-1:0]   csr_wdata
);

   ubxfr_pkg::cfg_type                cfg;
   ubxfr_pkg::rsp_word_type           result;

   logic                              in_valid_ff, in_valid_in;
   logic [ubxfr_pkg::ByteW-1:0]       in_byte_ff, in_byte_in;
   logic                              out_valid_ff, out_valid_in;
   ubxfr_pkg::rsp_word_type           out_word_ff, out_word_in;

   logic                              out_free;
   logic                              advance;
   logic                              in_accept;

   ubxfr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ubxfr_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .result  (result)
   );

   // Handshake: the byte register moves on whenever the result register frees up.
   assign out_free  = !out_valid_ff || rsp.ready;
   assign advance   = in_valid_ff && out_free;
   assign req.ready = !in_valid_ff || out_free;
   assign in_accept = req.valid && req.ready;

   // Input byte register.
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (in_accept) begin
         in_valid_in = 1'b1;
         in_byte_in  = req.rx_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // Result register.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_word_in  = out_word_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_word_in  = result;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      out_word_ff <= out_word_in;
   end

   // Result word onto the channel.
   assign rsp.valid          = out_valid_ff;
   assign rsp.payload_byte   = out_word_ff.payload_byte;
   assign rsp.payload_valid  = out_word_ff.payload_valid;
   assign rsp.payload_offset = out_word_ff.payload_offset;
   assign rsp.frame_status   = out_word_ff.frame_status;
   assign rsp.msg_class      = out_word_ff.msg_class;
   assign rsp.msg_id         = out_word_ff.msg_id;
   assign rsp.payload_length = out_word_ff.payload_length;

`ifndef SYNTHESIS
   // A payload word never carries a frame end status.
   a_payload_no_status: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.payload_valid) |-> (rsp.frame_status == ubxfr_pkg::ST_NONE))
      else $error("payload word carries a frame status");

   // A payload offset always lies inside the declared length.
   a_offset_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.payload_valid) |-> (rsp.payload_offset < rsp.payload_length))
      else $error("payload offset beyond declared length");

   // A held result keeps a waiting byte in the input register.
   a_stall_holds_byte: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && rsp.valid && !rsp.ready) |=> (in_valid_ff && $stable(in_byte_ff)))
      else $error("input byte lost during result stall");

   // Every processed byte produces a result word at the next edge.
   a_advance_gives_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp.valid)
      else $error("processed byte produced no result");
`endif

endmodule

### sim/ubxfr_checker.sv
// Scoreboard of the UBX frame receiver: predicts every result word and compares it.
module ubxfr_checker (
   input  logic                             clock,
   input  logic                             reset,
   ubxfr_req_if                             req,
   ubxfr_rsp_if                             rsp,
   input  logic                             csr_we,
   input  logic [ubxfr_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [ubxfr_pkg::CsrDataW-1:0]   csr_wdata,
   output int                               errors,
   output int                               pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import ubxfr_pkg::*;

   // Our own copy of the parser state and of the register set.
   cfg_type          cfg;
   phase_type        rx_phase;
   logic [ByteW-1:0] cur_class;
   logic [ByteW-1:0] cur_id;
   logic [LenW-1:0]  cur_length;
   logic [LenW-1:0]  pay_count;
   logic [ByteW-1:0] fl_a;
   logic [ByteW-1:0] fl_b;

   // Parsed words still owed by the block, oldest first.
   rsp_word_type     parse_results_q[$];

   // Fletcher sums wrap at eight bits on their own.
   function automatic void add_to_sums(input logic [ByteW-1:0] b);
      fl_a = fl_a + b;
      fl_b = fl_b + fl_a;
   endfunction

   // Takes one received byte and returns the word the block must answer with.
   function automatic rsp_word_type parse_rx_byte(input logic [ByteW-1:0] b);
      rsp_word_type w;
      w = '0;
      w.frame_status = ST_NONE;
      case (rx_phase)
         PH_HUNT2: begin
            rx_phase = (b == cfg.sync_second) ? PH_CLASS : PH_HUNT1;
         end
         PH_CLASS: begin
            cur_class = b;
            add_to_sums(b);
            rx_phase = PH_ID;
         end
         PH_ID: begin
            cur_id = b;
            add_to_sums(b);
            rx_phase = PH_LEN1;
         end
         PH_LEN1: begin
            cur_length = {8'h00, b};
            add_to_sums(b);
            rx_phase = PH_LEN2;
         end
         PH_LEN2: begin
            cur_length = {b, cur_length[7:0]};
            add_to_sums(b);
            if (cur_length > cfg.max_length) begin
               w.frame_status = ST_LONG;
               rx_phase = PH_HUNT1;
            end else if (cur_length == '0) begin
               rx_phase = PH_CK1;
            end else begin
               rx_phase = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            w.payload_byte   = b;
            w.payload_valid  = 1'b1;
            w.payload_offset = pay_count;
            add_to_sums(b);
            pay_count = pay_count + 1'b1;
            if (pay_count >= cur_length) begin
               rx_phase = PH_CK1;
            end
         end
         PH_CK1: begin
            if (b == fl_a) begin
               rx_phase = PH_CK2;
            end else begin
               w.frame_status = ST_BADCK;
               rx_phase = PH_HUNT1;
            end
         end
         PH_CK2: begin
            w.frame_status = (b == fl_b) ? ST_GOOD : ST_BADCK;
            rx_phase = PH_HUNT1;
         end
         default: begin
            // Hunting, and any phase code that is not defined.
            rx_phase = PH_HUNT1;
            if (b == cfg.sync_first) begin
               rx_phase   = PH_HUNT2;
               cur_class  = '0;
               cur_id     = '0;
               cur_length = '0;
               pay_count  = '0;
               fl_a       = '0;
               fl_b       = '0;
            end
         end
      endcase
      w.msg_class      = cur_class;
      w.msg_id         = cur_id;
      w.payload_length = cur_length;
      return w;
   endfunction

   function automatic string word_text(input rsp_word_type w);
      return $sformatf("byte=%02h pv=%0b off=%0d st=%0d cls=%02h id=%02h len=%0d",
                       w.payload_byte, w.payload_valid, w.payload_offset,
                       w.frame_status, w.msg_class, w.msg_id, w.payload_length);
   endfunction

   // Results are checked before new bytes are predicted: a word leaving at an
   // edge always belongs to a byte taken at an earlier edge.
   always @(posedge clock) begin
      rsp_word_type seen;
      rsp_word_type want;
      logic         bad;
      if (reset) begin
         cfg.sync_first  = SYNC_FIRST_RESET;
         cfg.sync_second = SYNC_SECOND_RESET;
         cfg.max_length  = MAX_LENGTH_RESET;
         rx_phase   = PH_HUNT1;
         cur_class  = '0;
         cur_id     = '0;
         cur_length = '0;
         pay_count  = '0;
         fl_a       = '0;
         fl_b       = '0;
         parse_results_q.delete();
         errors  = 0;
         pending = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            seen.payload_byte   = rsp.payload_byte;
            seen.payload_valid  = rsp.payload_valid;
            seen.payload_offset = rsp.payload_offset;
            seen.frame_status   = status_type'(rsp.frame_status);
            seen.msg_class      = rsp.msg_class;
            seen.msg_id         = rsp.msg_id;
            seen.payload_length = rsp.payload_length;
            if (parse_results_q.size() == 0) begin
               errors++;
               if (errors <= 10) begin
                  $display("%0t: result word with no byte behind it: %s",
                           $realtime, word_text(seen));
               end
            end else begin
               want = parse_results_q.pop_front();
               bad = (seen.payload_byte   !== want.payload_byte)   ||
                     (seen.payload_valid  !== want.payload_valid)  ||
                     (seen.payload_offset !== want.payload_offset) ||
                     (seen.frame_status   !== want.frame_status)   ||
                     (seen.msg_class      !== want.msg_class)      ||
                     (seen.msg_id         !== want.msg_id)         ||
                     (seen.payload_length !== want.payload_length);
               if (bad) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("%0t: word mismatch, expected %s", $realtime, word_text(want));
                     $display("%0t:                  actual %s", $realtime, word_text(seen));
                  end
               end
            end
         end

         // Register writes only happen while no bytes are in flight.
         if (csr_we) begin
            case (csr_index)
               CSR_SYNC_FIRST:  cfg.sync_first  = csr_wdata[ByteW-1:0];
               CSR_SYNC_SECOND: cfg.sync_second = csr_wdata[ByteW-1:0];
               CSR_MAX_LENGTH:  cfg.max_length  = csr_wdata[LenW-1:0];
               default: ;
            endcase
         end

         if (req.valid && req.ready) begin
            parse_results_q.push_back(parse_rx_byte(req.rx_byte));
         end
         pending = parse_results_q.size();
      end
   end

endmodule

### sim/tb_ubx_frame_receiver_unit.sv
// Testbench top of the UBX frame receiver: clock, reset, byte stimulus and verdict.
module tb_ubx_frame_receiver_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import ubxfr_pkg::*;

   typedef enum int {FL_NONE, FL_BAD_CKA, FL_BAD_CKB, FL_CUT} flaw_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_we;
   logic [CsrIdxW-1:0]  csr_index;
   logic [CsrDataW-1:0] csr_wdata;
   int                  fail_count;
   int                  words_pending;

   // Register values currently in the block, used to build frames.
   logic [ByteW-1:0]    sync_a_cfg;
   logic [ByteW-1:0]    sync_b_cfg;
   logic [LenW-1:0]     max_len_cfg;

   int                  sent_bytes;
   int                  burst_left;
   logic [8:0]          stall_cyc = '0;

   ubxfr_req_if req_ch ();
   ubxfr_rsp_if rsp_ch ();

   ubx_frame_receiver_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   ubxfr_checker frame_check (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .errors    (fail_count),
      .pending   (words_pending)
   );

   always #6 clock = ~clock;

   // The result side cycles through four stall patterns: none, random,
   // one cycle in four, and long runs of back-pressure.
   always @(negedge clock) begin
      stall_cyc <= stall_cyc + 1'b1;
      case (stall_cyc[8:7])
         2'd0:    rsp_ch.ready <= 1'b1;
         2'd1:    rsp_ch.ready <= ($urandom_range(0, 3) != 0);
         2'd2:    rsp_ch.ready <= (stall_cyc[1:0] == 2'd0);
         default: rsp_ch.ready <= (stall_cyc[3:0] >= 4'd10);
      endcase
   end

   // Sends one word. Bytes go out in bursts with random gaps between them.
   task automatic send_byte(input logic [ByteW-1:0] b);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         repeat (gap) begin
            req_ch.valid <= 1'b0;
            @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= b;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      burst_left--;
      sent_bytes++;
   endtask

   // Builds a frame with the current sync bytes and a random payload. A cut
   // frame stops after the given number of bytes.
   task automatic send_frame(input logic [ByteW-1:0] cls, input logic [ByteW-1:0] id,
                             input logic [LenW-1:0] len, input flaw_type flaw,
                             input int cut_at);
      logic [ByteW-1:0] frame_q[$];
      logic [ByteW-1:0] ck_a;
      logic [ByteW-1:0] ck_b;
      int               count;
      int               i;
      frame_q = {sync_a_cfg, sync_b_cfg, cls, id, len[7:0], len[15:8]};
      for (i = 0; i < len; i++) begin
         frame_q.push_back(8'($urandom));
      end
      ck_a = '0;
      ck_b = '0;
      for (i = 2; i < frame_q.size(); i++) begin
         ck_a = ck_a + frame_q[i];
         ck_b = ck_b + ck_a;
      end
      if (flaw == FL_BAD_CKA) begin
         ck_a = ck_a ^ (8'd1 << $urandom_range(0, 7));
      end
      if (flaw == FL_BAD_CKB) begin
         ck_b = ck_b ^ (8'd1 << $urandom_range(0, 7));
      end
      frame_q.push_back(ck_a);
      frame_q.push_back(ck_b);
      count = (flaw == FL_CUT) ? cut_at : frame_q.size();
      for (i = 0; i < count && i < frame_q.size(); i++) begin
         send_byte(frame_q[i]);
      end
   endtask

   // Mostly well-formed frames, with some line noise, bad sums, cut frames
   // and over-long headers mixed in.
   task automatic random_frames(input int stop_at);
      int       pick;
      int       lim;
      int       len_i;
      int       cut_at;
      flaw_type flaw;
      while (sent_bytes < stop_at) begin
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
         end
         pick   = $urandom_range(0, 15);
         cut_at = 0;
         if (pick == 0 && max_len_cfg != 16'hFFFF) begin
            // Over-long header; the block drops it after the length.
            len_i = int'(max_len_cfg) + 1 + $urandom_range(0, 300);
            if (len_i > 65535) begin
               len_i = 65535;
            end
            flaw   = FL_CUT;
            cut_at = $urandom_range(6, 9);
         end else begin
            lim = (pick == 1) ? 40 : 10;
            if (lim > int'(max_len_cfg)) begin
               lim = int'(max_len_cfg);
            end
            len_i = $urandom_range(0, lim);
            case ($urandom_range(0, 11))
               0:       flaw = FL_BAD_CKA;
               1:       flaw = FL_BAD_CKB;
               2: begin
                  flaw   = FL_CUT;
                  cut_at = $urandom_range(1, 5 + len_i);
               end
               default: flaw = FL_NONE;
            endcase
         end
         send_frame(8'($urandom), 8'($urandom), len_i[15:0], flaw, cut_at);
      end
   endtask

   // Stops sending and waits until every word sent has been answered.
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (words_pending != 0) begin
         @(negedge clock);
      end
      repeat (2) @(negedge clock);
      burst_left = 0;
   endtask

   task automatic set_config(input logic [ByteW-1:0] sf, input logic [ByteW-1:0] ss,
                             input logic [LenW-1:0] ml);
      drain();
      csr_we    <= 1'b1;
      csr_index <= CSR_SYNC_FIRST;
      csr_wdata <= {8'h00, sf};
      @(negedge clock);
      csr_index <= CSR_SYNC_SECOND;
      csr_wdata <= {8'h00, ss};
      @(negedge clock);
      csr_index <= CSR_MAX_LENGTH;
      csr_wdata <= ml;
      @(negedge clock);
      csr_we <= 1'b0;
      sync_a_cfg  = sf;
      sync_b_cfg  = ss;
      max_len_cfg = ml;
   endtask

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.rx_byte = '0;
      csr_we         = 1'b0;
      csr_index      = CSR_SYNC_FIRST;
      csr_wdata      = '0;
      sent_bytes     = 0;
      burst_left     = 0;
      sync_a_cfg     = SYNC_FIRST_RESET;
      sync_b_cfg     = SYNC_SECOND_RESET;
      max_len_cfg    = MAX_LENGTH_RESET;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Good frame with one payload byte, class and id at the byte extremes.
      send_frame(8'h00, 8'hFF, 16'd1, FL_NONE, 0);
      // A repeated first sync byte breaks the pair and does not restart it.
      send_byte(sync_a_cfg);
      send_byte(sync_a_cfg);
      send_byte(sync_b_cfg);
      // Length one past the maximum: only the header is sent.
      send_frame(8'h01, 8'h02, max_len_cfg + 16'd1, FL_CUT, 6);
      // Zero length goes straight to the sums; the first sum byte is wrong.
      send_frame(8'h12, 8'h34, 16'd0, FL_BAD_CKA, 0);

      random_frames(200);
      // Let the block run dry once in the middle of a setting.
      drain();
      random_frames(350);

      // Register extremes, then a random setting with a small maximum.
      set_config(8'h00, 8'hFF, 16'd0);
      random_frames(550);
      set_config(8'hFF, 8'h00, 16'hFFFF);
      random_frames(800);
      set_config(8'($urandom), 8'($urandom), 16'($urandom_range(1, 12)));
      random_frames(1050);

      drain();
      repeat (4) @(negedge clock);
      if (fail_count == 0 && words_pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #3ms;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
